// File: rtl/wfo_pkg.sv
// Package for the wheel frame odometry block: widths, constants, arctangent table.
// No dependencies; used by wfo_front, wfo_back and wheel_frame_odometry.
`default_nettype none
package wfo_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int StepW = $clog2(CORDIC_STEPS + 1);
	localparam logic signed [33:0] TwoPi  = 34'sd1686629713;
	localparam logic signed [33:0] Pi     = 34'sd843314857;
	localparam logic signed [33:0] HalfPi = 34'sd421657428;
	localparam logic [31:0] CordicGain = 32'h9B74EDA8;

	localparam logic CfgDist  = 1'b0;
	localparam logic CfgTrack = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIST, ST_ANGLE, ST_GAIN, ST_ROT, ST_DONE
	} back_state_t;

	// One classified frame as it waits between the front and back parts.
	typedef struct packed {
		logic        ok;
		logic        mode;
		logic [15:0] speed;
		logic [31:0] count;
	} frame_t;

	typedef struct packed {
		logic        frame_ok;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] heading_out;
		logic [15:0] linear_speed;
		logic [31:0] angular_rate;
	} result_t;

	function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0: r = 34'sd210828714;
			5'd1: r = 34'sd124459457;
			5'd2: r = 34'sd65760959;
			5'd3: r = 34'sd33381290;
			5'd4: r = 34'sd16755422;
			5'd5: r = 34'sd8385879;
			5'd6: r = 34'sd4193963;
			5'd7: r = 34'sd2097109;
			5'd8: r = 34'sd1048571;
			5'd9: r = 34'sd524287;
			5'd29, 5'd30, 5'd31: r = '0;
			default: r = 34'sd1 <<< (5'd28 - i);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/wfo_if.sv
// Valid/ready channel interfaces for frames, results and configuration writes.
// No dependencies.
`default_nettype none
interface wfo_frame_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7;
	modport source(output valid, mode, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
		byte_6, byte_7, input ready);
	modport sink(input valid, mode, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
		byte_6, byte_7, output ready);
endinterface

interface wfo_result_if;
	logic               valid;
	logic               ready;
	logic               frame_ok;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading_out;
	logic signed [15:0] linear_speed;
	logic signed [31:0] angular_rate;
	modport source(output valid, frame_ok, pos_x, pos_y, heading_out, linear_speed,
		angular_rate, input ready);
	modport sink(input valid, frame_ok, pos_x, pos_y, heading_out, linear_speed,
		angular_rate, output ready);
endinterface

interface wfo_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/wfo_front.sv
// Front part: accepts frame beats, checks the XOR checksum, and queues the frames.
// Depends on wfo_pkg and wfo_if.
`default_nettype none
module wfo_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	wfo_frame_if.sink          frame,
	output wfo_pkg::frame_t    q_data,
	output logic               q_valid,
	input  wire logic          q_pop
);
	wfo_pkg::frame_t slot_q [2];
	logic [1:0] fill_q;
	logic       rd_q;
	logic       wr_q;
	logic       ok;
	logic       push;

	// Checksum over bytes 0 to 6.
	assign ok = (frame.byte_0 ^ frame.byte_1 ^ frame.byte_2 ^ frame.byte_3 ^ frame.byte_4
		^ frame.byte_5 ^ frame.byte_6) == frame.byte_7;
	assign frame.ready = fill_q != 2'd2;
	assign push = frame.valid && frame.ready;
	assign q_valid = fill_q != 2'd0;
	assign q_data = slot_q[rd_q];

	// Two-entry queue of classified frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{ok: ok, mode: frame.mode,
				speed: {frame.byte_1, frame.byte_0},
				count: {frame.byte_5, frame.byte_4, frame.byte_3, frame.byte_2}};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q != 2'd3)
		else $error("queue fill out of range");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd2 && !q_pop) |=> fill_q == 2'd2)
		else $error("full queue lost an entry");
endmodule
`default_nettype wire

// File: rtl/wfo_back.sv
// Back part: wheel state, distance scaling, heading update and CORDIC rotation.
// Depends on wfo_pkg.
`default_nettype none
module wfo_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire wfo_pkg::frame_t q_data,
	input  wire logic          q_valid,
	output logic               q_pop,
	input  wire logic [31:0]   dist_per_pulse,
	input  wire logic [23:0]   inv_track,
	output wfo_pkg::result_t   res,
	output logic               res_valid,
	input  wire logic          res_ready
);
	wfo_pkg::back_state_t state_q, state_d;
	logic [31:0] lnow_q, lprev_q, rnow_q, rprev_q;
	logic        lseen_q, rseen_q;
	logic signed [15:0] lspd_q, rspd_q;
	logic [31:0] xacc_q, yacc_q;
	logic signed [31:0] head_q;
	logic        ok_q;
	logic signed [63:0] pl_q, pr_q;
	logic signed [33:0] dd_q, z_q;
	logic        flip_q;
	logic signed [35:0] x_q, y_q;
	logic [wfo_pkg::StepW-1:0] step_q;
	logic signed [59:0] dth_prod_q;
	logic        res_valid_q;
	wfo_pkg::result_t res_q;

	logic signed [63:0] pl_sh, pr_sh;
	logic signed [33:0] dl_n, dr_n, dth, ang, nh, z0, z1, z2;
	logic signed [59:0] dth_sh;
	logic signed [35:0] xs, ys;
	logic signed [67:0] gprod;
	logic signed [41:0] ar_prod;
	logic signed [41:0] ar_sh;
	logic signed [16:0] lin_sum;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= wfo_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		case (state_q)
			wfo_pkg::ST_IDLE: if (q_valid) begin
				q_pop   = 1'b1;
				state_d = wfo_pkg::ST_MUL;
			end
			wfo_pkg::ST_MUL:   state_d = wfo_pkg::ST_DIST;
			wfo_pkg::ST_DIST:  state_d = wfo_pkg::ST_ANGLE;
			wfo_pkg::ST_ANGLE: state_d = wfo_pkg::ST_GAIN;
			wfo_pkg::ST_GAIN:  state_d = wfo_pkg::ST_ROT;
			wfo_pkg::ST_ROT:
				if (step_q == wfo_pkg::StepW'(wfo_pkg::CORDIC_STEPS - 1))
					state_d = wfo_pkg::ST_DONE;
			wfo_pkg::ST_DONE: if (!res_valid_q || res_ready) state_d = wfo_pkg::ST_IDLE;
			default: state_d = wfo_pkg::ST_IDLE;
		endcase
	end

	// Datapath helpers.
	always_comb begin
		pl_sh = pl_q >>> 16;
		pr_sh = pr_q >>> 16;
		dl_n = (pl_sh > 64'sd2147483647) ? 34'sd2147483647 :
			(pl_sh < -64'sd2147483648) ? -34'sd2147483648 : 34'(pl_sh);
		dr_n = (pr_sh > 64'sd2147483647) ? 34'sd2147483647 :
			(pr_sh < -64'sd2147483648) ? -34'sd2147483648 : 34'(pr_sh);
		dth_sh = dth_prod_q >>> 4;
		dth = (dth_sh > 60'(wfo_pkg::TwoPi)) ? wfo_pkg::TwoPi :
			(dth_sh < -60'(wfo_pkg::TwoPi)) ? -wfo_pkg::TwoPi : 34'(dth_sh);
		ang = 34'(head_q) + dth;
		nh = ang;
		if (nh > wfo_pkg::TwoPi) nh = nh - wfo_pkg::TwoPi;
		if (nh < -wfo_pkg::TwoPi) nh = nh + wfo_pkg::TwoPi;
		z0 = ang;
		if (z0 > wfo_pkg::Pi) z0 = z0 - wfo_pkg::TwoPi;
		if (z0 > wfo_pkg::Pi) z0 = z0 - wfo_pkg::TwoPi;
		if (z0 <= -wfo_pkg::Pi) z0 = z0 + wfo_pkg::TwoPi;
		z1 = z0;
		if (z1 <= -wfo_pkg::Pi) z1 = z1 + wfo_pkg::TwoPi;
		z2 = z1;
		if (z1 > wfo_pkg::HalfPi) z2 = z1 - wfo_pkg::Pi;
		else if (z1 < -wfo_pkg::HalfPi) z2 = z1 + wfo_pkg::Pi;
		gprod = 68'(dd_q) * $signed({36'd0, wfo_pkg::CordicGain});
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		lin_sum = 17'(lspd_q) + 17'(rspd_q);
		ar_prod = 42'(17'(rspd_q) - 17'(lspd_q)) * $signed({18'd0, inv_track});
		ar_sh = ar_prod >>> 16;
	end

	// Wheel state and pose datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnow_q <= '0; lprev_q <= '0; rnow_q <= '0; rprev_q <= '0;
			lseen_q <= 1'b0; rseen_q <= 1'b0; lspd_q <= '0; rspd_q <= '0;
			xacc_q <= '0; yacc_q <= '0; head_q <= '0;
		end else begin
			case (state_q)
				wfo_pkg::ST_IDLE: if (q_valid) begin
					ok_q <= q_data.ok;
					if (q_data.ok && !q_data.mode) begin
						lspd_q <= q_data.speed; lnow_q <= q_data.count;
						if (!lseen_q) begin lprev_q <= q_data.count; lseen_q <= 1'b1; end
					end
					if (q_data.ok && q_data.mode) begin
						rspd_q <= q_data.speed; rnow_q <= q_data.count;
						if (!rseen_q) begin rprev_q <= q_data.count; rseen_q <= 1'b1; end
					end
				end
				wfo_pkg::ST_MUL: begin
					pl_q <= 64'($signed(lnow_q - lprev_q)) * $signed({32'd0, dist_per_pulse});
					pr_q <= 64'($signed(rnow_q - rprev_q)) * $signed({32'd0, dist_per_pulse});
					lprev_q <= lnow_q;
					rprev_q <= rnow_q;
				end
				wfo_pkg::ST_DIST: begin
					dd_q <= (dl_n + dr_n) >>> 1;
					dth_prod_q <= 60'(dr_n - dl_n) * $signed({36'd0, inv_track});
				end
				wfo_pkg::ST_ANGLE: begin
					z_q <= z2;
					flip_q <= (z1 > wfo_pkg::HalfPi) || (z1 < -wfo_pkg::HalfPi);
					head_q <= 32'(nh);
				end
				wfo_pkg::ST_GAIN: begin
					x_q <= 36'(gprod >>> 32);
					y_q <= '0;
					step_q <= '0;
				end
				wfo_pkg::ST_ROT: begin
					if (!z_q[33]) begin
						x_q <= x_q - ys; y_q <= y_q + xs;
						z_q <= z_q - wfo_pkg::atan_entry(5'(step_q));
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs;
						z_q <= z_q + wfo_pkg::atan_entry(5'(step_q));
					end
					step_q <= step_q + 1'b1;
				end
				wfo_pkg::ST_DONE: if (!res_valid_q || res_ready) begin
					xacc_q <= xacc_q + (flip_q ? 32'(-x_q) : 32'(x_q));
					yacc_q <= yacc_q + (flip_q ? 32'(-y_q) : 32'(y_q));
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (state_q == wfo_pkg::ST_DONE && (!res_valid_q || res_ready))
			res_valid_q <= 1'b1;
		else if (res_ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == wfo_pkg::ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.frame_ok     <= ok_q;
			res_q.pos_x        <= xacc_q + (flip_q ? 32'(-x_q) : 32'(x_q));
			res_q.pos_y        <= yacc_q + (flip_q ? 32'(-y_q) : 32'(y_q));
			res_q.heading_out  <= head_q;
			res_q.linear_speed <= lin_sum[16:1];
			res_q.angular_rate <= (ar_sh > 42'sd2147483647) ? 32'h7FFFFFFF :
				(ar_sh < -42'sd2147483648) ? 32'h80000000 : 32'(ar_sh);
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == wfo_pkg::ST_IDLE)
		else $error("frame taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wfo_pkg::ST_ROT |-> step_q < wfo_pkg::StepW'(wfo_pkg::CORDIC_STEPS))
		else $error("rotation step overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> ($stable(res_q) && res_valid_q))
		else $error("stalled result changed");
endmodule
`default_nettype wire

// File: rtl/wheel_frame_odometry.sv
// Path from frame beat to result beat: the queue, the setup states (IDLE, MUL, DIST,
// ANGLE, GAIN), CORDIC_STEPS rotation steps and the result register. The back part
// takes no new frame until it is through with the last one: one shared CORDIC loop.
// Reset clears pose, wheel state and registers (inv_track to 1.0 in Q8.16) at once.
// Depends on wfo_pkg, wfo_if, wfo_front, wfo_back.
`default_nettype none
module wheel_frame_odometry (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wfo_frame_if.sink   frame,
	wfo_result_if.source result,
	wfo_cfg_if.sink     cfg
);
	wfo_pkg::frame_t  q_data;
	logic             q_valid, q_pop;
	wfo_pkg::result_t res;
	logic [31:0]      dist_q;
	logic [23:0]      track_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q  <= '0;
			track_q <= 24'd65536;
		end else if (cfg.valid) begin
			if (cfg.index == wfo_pkg::CfgDist) dist_q <= cfg.data;
			else track_q <= cfg.data[23:0];
		end
	end

	wfo_front u_front (.clk(clk), .arst_n(arst_n), .frame(frame), .q_data(q_data),
		.q_valid(q_valid), .q_pop(q_pop));

	wfo_back u_back (.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .dist_per_pulse(dist_q), .inv_track(track_q), .res(res),
		.res_valid(result.valid), .res_ready(result.ready));

	assign result.frame_ok     = res.frame_ok;
	assign result.pos_x        = res.pos_x;
	assign result.pos_y        = res.pos_y;
	assign result.heading_out  = res.heading_out;
	assign result.linear_speed = res.linear_speed;
	assign result.angular_rate = res.angular_rate;
endmodule
`default_nettype wire

// File: tb/wfo_tb_pkg.sv
// Shared testbench declarations: the expected-result record for the odometry checker.
// No dependencies.
package wfo_tb_pkg;
	typedef struct {
		logic        frame_ok;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] heading_out;
		logic [15:0] linear_speed;
		logic [31:0] angular_rate;
	} pose_t;
endpackage

// File: tb/wfo_checker.sv
// Checker for the wheel frame odometry block: predicts the pose for each frame beat
// and compares result beats in order. Depends on wfo_pkg, wfo_tb_pkg and wfo_if.
module wfo_checker (
	input  logic        clk,
	input  logic        arst_n,
	wfo_frame_if        frame,
	wfo_result_if       result,
	wfo_cfg_if          cfg,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint TWO_PI_L  = 64'sd1686629713;
	localparam longint PI_L      = 64'sd843314857;
	localparam longint HALF_PI_L = 64'sd421657428;
	localparam longint GAIN_L    = 64'sd2608131496;
	localparam longint S32_MIN   = -64'sd2147483648;
	localparam longint S32_MAX   = 64'sd2147483647;

	// Shadow of the block's registers and odometry state.
	logic [31:0] m_dist;
	logic [23:0] m_track;
	logic [31:0] l_now, l_prev, r_now, r_prev;
	logic        l_seen, r_seen;
	longint      l_spd, r_spd;
	logic [31:0] x_sum, y_sum;
	longint      head;
	wfo_tb_pkg::pose_t pose_q[$];

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint arctan(int i);
		longint t[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10) return t[i];
		if (i > 28) return 0;
		return 64'sd1 <<< (28 - i);
	endfunction

	function automatic longint travel(logic [31:0] now, logic [31:0] prev);
		logic [31:0] d;
		d = now - prev;
		return clamp((longint'($signed(d)) * longint'({32'b0, m_dist})) >>> 16,
			S32_MIN, S32_MAX);
	endfunction

	// Advance the pose by one frame and return the expected result.
	function automatic wfo_tb_pkg::pose_t odometry_step(logic md, logic [7:0] b[8]);
		wfo_tb_pkg::pose_t p;
		logic [7:0] sum;
		logic   ok, flip;
		longint dl, dr, dd, dth, ang, nh, x, y, z, xs, ys;
		sum = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
		ok = (sum == b[7]);
		if (ok) begin
			if (!md) begin
				l_spd = longint'($signed({b[1], b[0]}));
				l_now = {b[5], b[4], b[3], b[2]};
				if (!l_seen) begin
					l_prev = l_now;
					l_seen = 1'b1;
				end
			end else begin
				r_spd = longint'($signed({b[1], b[0]}));
				r_now = {b[5], b[4], b[3], b[2]};
				if (!r_seen) begin
					r_prev = r_now;
					r_seen = 1'b1;
				end
			end
		end
		dl = travel(l_now, l_prev);
		dr = travel(r_now, r_prev);
		dd = (dl + dr) >>> 1;
		dth = clamp(((dr - dl) * longint'({40'b0, m_track})) >>> 4, -TWO_PI_L, TWO_PI_L);
		ang = head + dth;
		l_prev = l_now;
		r_prev = r_now;
		nh = ang;
		if (nh > TWO_PI_L) nh -= TWO_PI_L;
		if (nh < -TWO_PI_L) nh += TWO_PI_L;
		// Reduce the angle to (-pi, pi], then fold into the CORDIC's range.
		z = ang;
		flip = 1'b0;
		repeat (2) if (z > PI_L) z -= TWO_PI_L;
		repeat (2) if (z <= -PI_L) z += TWO_PI_L;
		if (z > HALF_PI_L) begin
			z -= PI_L;
			flip = 1'b1;
		end else if (z < -HALF_PI_L) begin
			z += PI_L;
			flip = 1'b1;
		end
		x = (dd * GAIN_L) >>> 32;
		y = 0;
		for (int i = 0; i < wfo_pkg::CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arctan(i);
			end else begin
				x += ys; y -= xs; z += arctan(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		x_sum += x[31:0];
		y_sum += y[31:0];
		head = nh;
		p.frame_ok = ok;
		p.pos_x = x_sum;
		p.pos_y = y_sum;
		p.heading_out = nh[31:0];
		dd = (l_spd + r_spd) >>> 1;
		p.linear_speed = dd[15:0];
		dd = clamp(((r_spd - l_spd) * longint'({40'b0, m_track})) >>> 16, S32_MIN, S32_MAX);
		p.angular_rate = dd[31:0];
		return p;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		wfo_tb_pkg::pose_t e;
		logic [7:0] b[8];
		if (!arst_n) begin
			m_dist = '0; m_track = 24'd65536;
			l_now = '0; l_prev = '0; r_now = '0; r_prev = '0;
			l_seen = 1'b0; r_seen = 1'b0; l_spd = 0; r_spd = 0;
			x_sum = '0; y_sum = '0; head = 0;
			fail_count = 0;
			pose_q.delete();
		end else begin
			// Register writes.
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == wfo_pkg::CfgDist) m_dist = cfg.data;
				else m_track = cfg.data[23:0];
			end
			// Frame beats produce expectations.
			if (frame.valid && frame.ready) begin
				b = '{frame.byte_0, frame.byte_1, frame.byte_2, frame.byte_3,
					frame.byte_4, frame.byte_5, frame.byte_6, frame.byte_7};
				pose_q.push_back(odometry_step(frame.mode, b));
			end
			// Result beats are checked against the oldest expectation.
			if (result.valid && result.ready) begin
				if (pose_q.size() == 0) begin
					report("unexpected result beat", 32'd0, 32'd0);
				end else begin
					e = pose_q.pop_front();
					if (result.frame_ok !== e.frame_ok)
						report("frame_ok", result.frame_ok, e.frame_ok);
					if (result.pos_x !== e.pos_x) report("pos_x", result.pos_x, e.pos_x);
					if (result.pos_y !== e.pos_y) report("pos_y", result.pos_y, e.pos_y);
					if (result.heading_out !== e.heading_out)
						report("heading_out", result.heading_out, e.heading_out);
					if (result.linear_speed !== e.linear_speed)
						report("linear_speed", result.linear_speed, e.linear_speed);
					if (result.angular_rate !== e.angular_rate)
						report("angular_rate", result.angular_rate, e.angular_rate);
				end
			end
		end
		pending = pose_q.size();
	end
endmodule

// File: tb/tb.sv
// Top of the odometry testbench: clock, reset, frame and register stimulus, verdict.
// Depends on wfo_pkg, wfo_if, wfo_tb_pkg, wfo_checker and the block itself.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending;
	int   idle_pct = 0, stall_pct = 0;
	int   hold_cycles = 0;
	int   quiet = 0;
	logic [31:0] cnt_l = '0, cnt_r = '0;

	wfo_frame_if  frame ();
	wfo_result_if result ();
	wfo_cfg_if    cfg ();

	wheel_frame_odometry dut (.clk(clk), .arst_n(arst_n), .frame(frame.sink),
		.result(result.source), .cfg(cfg.sink));
	wfo_checker chk (.clk(clk), .arst_n(arst_n), .frame(frame), .result(result),
		.cfg(cfg), .fail_count(fail_count), .pending(pending));

	always #1 clk = ~clk;

	// Result side: random stalls, plus a long hold-off when one is requested.
	initial result.ready = 1'b0;
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: cycles with no beat on any channel.
	always @(posedge clk) begin
		if ((frame.valid && frame.ready) || (result.valid && result.ready) ||
			(cfg.valid && cfg.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge once the write is taken and valid is low.
	task automatic write_reg(logic idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one frame at a falling edge, after a random gap ahead of it.
	// Returns at the accepting edge; valid is left high for the next frame or drain.
	task automatic send(logic md, logic [7:0] b[8]);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			frame.valid <= 1'b0;
			@(negedge clk);
		end
		frame.valid <= 1'b1;
		frame.mode <= md;
		{frame.byte_0, frame.byte_1, frame.byte_2, frame.byte_3} <= {b[0], b[1], b[2], b[3]};
		{frame.byte_4, frame.byte_5, frame.byte_6, frame.byte_7} <= {b[4], b[5], b[6], b[7]};
		do @(posedge clk); while (!frame.ready);
	endtask

	// Build a frame; a good checksum unless broken.
	task automatic wheel_frame(logic md, logic [15:0] spd, logic [31:0] cnt, logic bad,
		logic [7:0] b6);
		logic [7:0] b[8];
		b[0] = spd[7:0]; b[1] = spd[15:8];
		b[2] = cnt[7:0]; b[3] = cnt[15:8]; b[4] = cnt[23:16]; b[5] = cnt[31:24];
		b[6] = b6;
		b[7] = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5] ^ b[6];
		if (bad) b[7] ^= 8'($urandom_range(255, 1));
		send(md, b);
	endtask

	task automatic random_frame();
		logic md;
		logic [31:0] step, c;
		md = $urandom_range(1);
		case ($urandom_range(9))
			0: step = $urandom;
			1: step = -($urandom_range(5000));
			default: step = $urandom_range(3000);
		endcase
		c = (md ? cnt_r : cnt_l) + step;
		if (md) cnt_r = c; else cnt_l = c;
		wheel_frame(md, 16'($urandom), c, ($urandom_range(9) == 0), 8'($urandom));
	endtask

	// Follows the last send: drop valid, then wait for every expected result.
	task automatic drain();
		@(negedge clk);
		frame.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		logic [7:0] raw[8];
		frame.valid = 1'b0; frame.mode = 1'b0;
		{frame.byte_0, frame.byte_1, frame.byte_2, frame.byte_3} = '0;
		{frame.byte_4, frame.byte_5, frame.byte_6, frame.byte_7} = '0;
		cfg.valid = 1'b0; cfg.index = wfo_pkg::CfgDist; cfg.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: default registers, first frames seed counts, then extremes.
		wheel_frame(1'b0, 16'h7FFF, 32'h0000_1000, 1'b0, 8'h00);
		wheel_frame(1'b1, 16'h8000, 32'hFFFF_FFFF, 1'b0, 8'hFF);
		wheel_frame(1'b0, 16'd100, 32'h0000_2000, 1'b1, 8'h5A);
		drain();
		write_reg(wfo_pkg::CfgDist, 32'hFFFF_FFFF);
		write_reg(wfo_pkg::CfgTrack, 32'h00FF_FFFF);
		wheel_frame(1'b0, 16'hFFFF, 32'h8000_1000, 1'b0, 8'hA5);
		wheel_frame(1'b1, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, 8'h00);
		wheel_frame(1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b0, 8'h00);
		wheel_frame(1'b0, 16'h8000, 32'h0000_1000, 1'b0, 8'hFF);
		raw = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send(1'b1, raw);
		raw = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send(1'b0, raw);
		drain();
		cnt_l = 32'h0000_1000; cnt_r = 32'hFFFF_FFFF;

		// Random phases: register settings and idling combinations.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			write_reg(wfo_pkg::CfgDist, (ph == 0) ? 32'd0 :
				(ph == 7) ? 32'hFFFF_FFFF : 32'($urandom_range(32'h00FF_FFFF)));
			write_reg(wfo_pkg::CfgTrack, (ph == 5) ? 32'd0 : (ph == 6) ? 32'h00FF_FFFF :
				32'($urandom_range(24'h03_FFFF)));
			if (ph == 2) hold_cycles = 600;
			for (int n = 0; n < 100; n++) random_frame();
			drain();
		end

		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
